### rtl/iugf_pkg.sv
package iugf_pkg;

	localparam int MaxHits = 32;
	localparam int CntW = $clog2(MaxHits + 1);
	localparam int IdxW = $clog2(MaxHits);
	localparam int CoordW = 31;
	localparam int NumW = 7;
	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] RegDocHeight = 2'd0;
	localparam logic [CfgIdxW-1:0] RegPadding = 2'd1;
	localparam logic [CfgIdxW-1:0] RegMinGap = 2'd2;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_RUN = 1'b1
	} op_t;

	typedef struct packed {
		logic op;
		logic signed [31:0] hit_start;
		logic signed [31:0] hit_end;
	} in_item_t;

	typedef struct packed {
		logic [CoordW-1:0] gap_start;
		logic [CoordW-1:0] gap_end;
		logic [NumW-1:0] gap_number;
		logic gap_valid;
		logic overflow;
		logic last;
	} out_item_t;

	// normalized command passed from front to back
	typedef struct packed {
		logic run;
		logic keep;
		logic [CoordW-1:0] lo;
		logic [CoordW-1:0] hi;
	} cmd_t;

endpackage

### rtl/iugf_front.sv
module iugf_front import iugf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_item,
	input logic [CoordW-1:0] doc_height,
	input logic [CoordW-1:0] padding,
	output logic cmd_valid,
	input logic cmd_ready,
	output cmd_t cmd
);

	logic signed [33:0] a, b, lo, hi, lo_p, hi_p;
	logic [CoordW-1:0] y0, y1;
	logic full_q;
	logic [1:0] cnt_q;
	cmd_t q_q [2];
	logic rd_q, wr_q;
	logic push_c, pop_c;

	// order, pad, clamp
	always_comb begin
		a = 34'(in_item.hit_start);
		b = 34'(in_item.hit_end);
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		lo_p = lo - 34'($signed({3'b0, padding}));
		hi_p = hi + 34'($signed({3'b0, padding}));
		if (lo_p < 0) y0 = '0;
		else if (lo_p > $signed({3'b0, doc_height})) y0 = doc_height;
		else y0 = lo_p[CoordW-1:0];
		if (hi_p < 0) y1 = '0;
		else if (hi_p > $signed({3'b0, doc_height})) y1 = doc_height;
		else y1 = hi_p[CoordW-1:0];
	end

	// two-entry queue toward the back end
	assign in_ready = (cnt_q != 2'd2);
	assign push_c = in_valid && in_ready;
	assign pop_c = cmd_valid && cmd_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rd_q];
	assign full_q = (cnt_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push_c) wr_q <= ~wr_q;
			if (pop_c) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push_c) - 2'(pop_c);
		end
	end

	always_ff @(posedge clk) begin
		if (push_c) begin
			q_q[wr_q].run <= (in_item.op == OP_RUN);
			q_q[wr_q].keep <= (y1 > y0);
			q_q[wr_q].lo <= y0;
			q_q[wr_q].hi <= y1;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> !push_c) else $error("push into full queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop_c |-> cnt_q != 2'd0) else $error("pop from empty queue");

endmodule

### rtl/iugf_back.sv
module iugf_back import iugf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input cmd_t cmd,
	input logic [CoordW-1:0] doc_height,
	input logic [CoordW-1:0] min_gap,
	output logic empty,
	input logic pop,
	output out_item_t result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_TAIL,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic [CoordW-1:0] lo_q [MaxHits];
	logic [CoordW-1:0] hi_q [MaxHits];
	logic [CntW-1:0] count_q;
	logic ovf_q;
	logic [CntW-1:0] idx_q;
	logic [CoordW-1:0] cur_q, m0_q, m1_q;
	logic open_q;
	logic [NumW-1:0] num_q;
	logic out_full_q;
	out_item_t out_q;
	out_item_t pend_q;
	logic pend_v_q;

	logic [MaxHits-1:0] gt;
	logic load_c, ins_c, emit_ok;
	logic [IdxW-1:0] ri;
	logic [CoordW-1:0] e_lo, e_hi;
	logic more;
	logic close_c, gap_ok, tail_ok, emit_c;

	assign ri = idx_q[IdxW-1:0];
	assign e_lo = lo_q[ri];
	assign e_hi = hi_q[ri];
	assign more = (idx_q < count_q);
	assign emit_ok = !out_full_q || pop;
	assign empty = !out_full_q;
	assign result = out_q;
	assign cmd_ready = (state_q == ST_IDLE) && (cmd.run ? emit_ok : 1'b1);
	assign load_c = cmd_valid && cmd_ready && !cmd.run;
	assign ins_c = load_c && cmd.keep && (count_q != CntW'(MaxHits));
	assign close_c = (state_q == ST_SWEEP) && open_q && !(more && e_lo <= m1_q);
	assign gap_ok = {1'b0, m0_q} >= {1'b0, cur_q} + {1'b0, min_gap};
	assign tail_ok = {1'b0, doc_height} >= {1'b0, cur_q} + {1'b0, min_gap};

	// per-slot compare for insertion into the sorted shift chain
	always_comb begin
		for (int k = 0; k < MaxHits; k++)
			gt[k] = (CntW'(k) < count_q) && (lo_q[k] > cmd.lo);
	end

	// slots above the new edge move up one, the first of them takes the new span
	always_ff @(posedge clk) begin
		if (ins_c) begin
			for (int k = 0; k < MaxHits; k++) begin
				if (k > 0 && gt[(k+MaxHits-1)%MaxHits]) begin
					lo_q[k] <= lo_q[(k+MaxHits-1)%MaxHits];
					hi_q[k] <= hi_q[(k+MaxHits-1)%MaxHits];
				end else if (gt[k] || CntW'(k) == count_q) begin
					lo_q[k] <= cmd.lo;
					hi_q[k] <= cmd.hi;
				end
			end
		end
	end

	// a result is written into the output register this cycle
	always_comb begin
		case (state_q)
			ST_IDLE: emit_c = cmd_valid && cmd_ready && cmd.run
				&& (doc_height == '0 || count_q == '0);
			ST_SWEEP: emit_c = close_c && gap_ok && pend_v_q && emit_ok;
			ST_TAIL: emit_c = emit_ok && (tail_ok ? pend_v_q : !pend_v_q);
			ST_FLUSH: emit_c = emit_ok;
			default: emit_c = 1'b0;
		endcase
	end

	// output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_full_q <= 1'b0;
		else if (emit_c) out_full_q <= 1'b1;
		else if (pop) out_full_q <= 1'b0;
	end

	// sweep sequencer and output register; each gap waits in pend_q
	// until the next one is known, so the final gap can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
			idx_q <= '0;
			cur_q <= '0;
			m0_q <= '0;
			m1_q <= '0;
			open_q <= 1'b0;
			num_q <= '0;
			out_q <= '0;
			pend_q <= '0;
			pend_v_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (load_c && cmd.keep) begin
						if (ins_c) count_q <= count_q + 1'b1;
						else ovf_q <= 1'b1;
					end
					if (cmd_valid && cmd_ready && cmd.run) begin
						idx_q <= '0;
						cur_q <= '0;
						open_q <= 1'b0;
						num_q <= '0;
						pend_v_q <= 1'b0;
						if (doc_height == '0 || count_q == '0) begin
							out_q <= '{gap_start: '0, gap_end: '0, gap_number: '0,
								gap_valid: 1'b0, overflow: ovf_q, last: 1'b1};
							count_q <= '0;
							ovf_q <= 1'b0;
						end else begin
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_SWEEP: begin
					if (more && !open_q) begin
						m0_q <= e_lo;
						m1_q <= e_hi;
						open_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end else if (more && e_lo <= m1_q) begin
						if (e_hi > m1_q) m1_q <= e_hi;
						idx_q <= idx_q + 1'b1;
					end else if (open_q) begin
						// close merged span: gap before it
						if (gap_ok) begin
							if (!pend_v_q || emit_ok) begin
								if (pend_v_q) out_q <= pend_q;
								pend_q <= '{gap_start: cur_q, gap_end: m0_q,
									gap_number: num_q + 1'b1, gap_valid: 1'b1,
									overflow: ovf_q, last: 1'b0};
								pend_v_q <= 1'b1;
								num_q <= num_q + 1'b1;
								cur_q <= m1_q;
								open_q <= 1'b0;
							end
						end else begin
							cur_q <= m1_q;
							open_q <= 1'b0;
						end
					end else begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					if (tail_ok) begin
						if (!pend_v_q || emit_ok) begin
							if (pend_v_q) out_q <= pend_q;
							pend_q <= '{gap_start: cur_q, gap_end: doc_height,
								gap_number: num_q + 1'b1, gap_valid: 1'b1,
								overflow: ovf_q, last: 1'b0};
							pend_v_q <= 1'b1;
							num_q <= num_q + 1'b1;
							state_q <= ST_FLUSH;
						end
					end else if (pend_v_q) begin
						state_q <= ST_FLUSH;
					end else if (emit_ok) begin
						// no gap passed: marker result
						out_q <= '{gap_start: '0, gap_end: '0, gap_number: '0,
							gap_valid: 1'b0, overflow: ovf_q, last: 1'b1};
						count_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (emit_ok) begin
						out_q <= '{gap_start: pend_q.gap_start, gap_end: pend_q.gap_end,
							gap_number: pend_q.gap_number, gap_valid: 1'b1,
							overflow: pend_q.overflow, last: 1'b1};
						pend_v_q <= 1'b0;
						count_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxHits)) else $error("span count too large");
	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && emit_ok) |=> (count_q == '0 && !ovf_q))
		else $error("run did not clear store");
	a_sweep_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> idx_q <= count_q) else $error("sweep index past count");

endmodule

### rtl/interval_union_gap_finder.sv
// Interval union gap finder.
// Input queue side: push/full with op, hit_start, hit_end. A load transaction
// normalizes the span (order, pad, clamp) and inserts it sorted into a
// 32-entry store; loads sustain one per cycle. Empty spans are dropped and a
// full store sets overflow instead. A run transaction sweeps the stored
// spans in order, merging spans and emitting gaps. Each gap is held back
// until the next one is known so the final result can be marked last. The
// single sweep sequencer in the back end carries out each run, and loads
// wait while it runs, since the back end takes commands only when idle.
// Result queue side: empty/pop, one result register; the oldest result is
// shown while empty is low. A stalled pop holds the sweep; the two-entry
// command queue between front and back takes up to two more transactions.
// Config writes via cfg_valid/cfg_ready (always ready); the user writes only
// while idle, the block does not enforce it. Reset clears counts, flags and registers; store contents are don't care.
module interval_union_gap_finder import iugf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input in_item_t in_item,
	output logic empty,
	input logic pop,
	output out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [31:0] cfg_data
);

	logic [CoordW-1:0] doc_height_q, padding_q, min_gap_q;
	logic in_ready, cmd_valid, cmd_ready;
	cmd_t cmd;

	assign cfg_ready = 1'b1;
	assign full = !in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			doc_height_q <= '0;
			padding_q <= '0;
			min_gap_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegDocHeight: doc_height_q <= cfg_data[CoordW-1:0];
				RegPadding: padding_q <= cfg_data[CoordW-1:0];
				RegMinGap: min_gap_q <= cfg_data[CoordW-1:0];
				default: ;
			endcase
		end
	end

	iugf_front u_front (
		.clk, .arst_n,
		.in_valid(push), .in_ready, .in_item,
		.doc_height(doc_height_q), .padding(padding_q),
		.cmd_valid, .cmd_ready, .cmd
	);

	iugf_back u_back (
		.clk, .arst_n,
		.cmd_valid, .cmd_ready, .cmd,
		.doc_height(doc_height_q), .min_gap(min_gap_q),
		.empty, .pop, .result(out_item)
	);

endmodule

### bench/gap_checker.sv
module gap_checker import iugf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input in_item_t in_item,
	input logic empty,
	input logic pop,
	input out_item_t out_item,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [31:0] cfg_data,
	output int fail_count,
	output int pending_gaps
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CoordW-1:0] doc_h, pad, min_g;
	logic [CoordW-1:0] span_lo [MaxHits];
	logic [CoordW-1:0] span_hi [MaxHits];
	int span_cnt;
	bit ovf_flag;
	out_item_t gap_queue [$];

	assign pending_gaps = gap_queue.size();

	// clamp a signed edge into [0, doc_h]
	function automatic logic [CoordW-1:0] clamp_edge(longint v);
		if (v < 0) return '0;
		if (v > longint'(doc_h)) return doc_h;
		return v[CoordW-1:0];
	endfunction

	// normalize one hit and insert it sorted by lower edge
	task automatic load_hit(in_item_t it);
		longint a, b, lo, hi;
		logic [CoordW-1:0] y0, y1;
		int p;
		a = longint'(it.hit_start);
		b = longint'(it.hit_end);
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		y0 = clamp_edge(lo - longint'(pad));
		y1 = clamp_edge(hi + longint'(pad));
		if (y1 <= y0) return;
		if (span_cnt >= MaxHits) begin
			ovf_flag = 1;
			return;
		end
		p = span_cnt;
		while (p > 0 && span_lo[p-1] > y0) begin
			span_lo[p] = span_lo[p-1];
			span_hi[p] = span_hi[p-1];
			p--;
		end
		span_lo[p] = y0;
		span_hi[p] = y1;
		span_cnt++;
	endtask

	function automatic out_item_t make_gap(logic [CoordW-1:0] s, logic [CoordW-1:0] e,
			int num, bit vld);
		out_item_t r;
		r.gap_start = s;
		r.gap_end = e;
		r.gap_number = num[NumW-1:0];
		r.gap_valid = vld;
		r.overflow = ovf_flag;
		r.last = 0;
		return r;
	endfunction

	// merge sweep; queue the expected gaps of one run
	task automatic predict_gaps();
		out_item_t found [$];
		logic [CoordW-1:0] cur, m0, m1;
		int i;
		cur = '0;
		i = 0;
		if (doc_h != 0 && span_cnt != 0) begin
			while (i < span_cnt) begin
				m0 = span_lo[i];
				m1 = span_hi[i];
				i++;
				while (i < span_cnt && span_lo[i] <= m1) begin
					if (span_hi[i] > m1) m1 = span_hi[i];
					i++;
				end
				if (longint'(m0) - longint'(cur) >= longint'(min_g))
					found = {found, make_gap(cur, m0, found.size() + 1, 1)};
				cur = m1;
			end
			if (longint'(doc_h) - longint'(cur) >= longint'(min_g))
				found = {found, make_gap(cur, doc_h, found.size() + 1, 1)};
		end
		if (found.size() == 0) found = {found, make_gap('0, '0, 0, 0)};
		found[found.size()-1].last = 1;
		gap_queue = {gap_queue, found};
		span_cnt = 0;
		ovf_flag = 0;
	endtask

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_gap;
		if (!arst_n) begin
			doc_h = '0;
			pad = '0;
			min_g = '0;
			span_cnt = 0;
			ovf_flag = 0;
			fail_count = 0;
			gap_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					RegDocHeight: doc_h = cfg_data[CoordW-1:0];
					RegPadding: pad = cfg_data[CoordW-1:0];
					RegMinGap: min_g = cfg_data[CoordW-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (gap_queue.size() == 0) begin
					$error("unexpected result transaction %p", out_item);
					fail_count++;
				end else begin
					exp_gap = gap_queue.pop_front();
					if (out_item.gap_start !== exp_gap.gap_start) begin
						$error("gap_start exp %0h got %0h", exp_gap.gap_start, out_item.gap_start);
						fail_count++;
					end
					if (out_item.gap_end !== exp_gap.gap_end) begin
						$error("gap_end exp %0h got %0h", exp_gap.gap_end, out_item.gap_end);
						fail_count++;
					end
					if (out_item.gap_number !== exp_gap.gap_number) begin
						$error("gap_number exp %0d got %0d", exp_gap.gap_number,
							out_item.gap_number);
						fail_count++;
					end
					if (out_item.gap_valid !== exp_gap.gap_valid) begin
						$error("gap_valid exp %0b got %0b", exp_gap.gap_valid, out_item.gap_valid);
						fail_count++;
					end
					if (out_item.overflow !== exp_gap.overflow) begin
						$error("overflow exp %0b got %0b", exp_gap.overflow, out_item.overflow);
						fail_count++;
					end
					if (out_item.last !== exp_gap.last) begin
						$error("last exp %0b got %0b", exp_gap.last, out_item.last);
						fail_count++;
					end
				end
			end
			if (push && !full) begin
				if (in_item.op == OP_RUN) predict_gaps();
				else load_hit(in_item);
			end
		end
	end
endmodule

### bench/tb_top.sv
module tb_top import iugf_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic clk, arst_n, push, full, empty, pop, cfg_valid, cfg_ready;
	in_item_t in_item;
	out_item_t out_item;
	logic [CfgIdxW-1:0] cfg_index;
	logic [31:0] cfg_data;
	int fail_count, pending_gaps;
	int gap_left, stall_mode;

	interval_union_gap_finder i_dut (.*);
	gap_checker i_chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("interval_union_gap_finder verification failed");
		$finish;
	end

	// result side: stalls in changing patterns, sometimes none
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: pop <= 1;
				1: pop <= ($urandom_range(0, 3) != 0);
				2: pop <= $urandom_range(0, 1);
				default: pop <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	// one transaction, held until accepted
	task automatic send(logic op, logic [31:0] s, logic [31:0] e);
		if (gap_left == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			gap_left = $urandom_range(1, 20);
		end
		in_item.op <= op;
		in_item.hit_start <= s;
		in_item.hit_end <= e;
		push <= 1;
		do @(posedge clk); while (full);
		gap_left--;
	endtask

	task automatic drain();
		push <= 0;
		while (pending_gaps != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_coord(logic [31:0] h);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h8000_0000 | $urandom_range(0, 3);
			2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			default: return $urandom_range(0, h + h / 8);
		endcase
	endfunction

	initial begin
		int n;
		logic [31:0] h;
		arst_n = 0;
		push = 0;
		cfg_valid = 0;
		cfg_index = RegDocHeight;
		cfg_data = 0;
		in_item = '0;
		gap_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: run with zero height and empty store
		send(OP_RUN, 0, 0);
		send(OP_LOAD, 5, 9);
		send(OP_RUN, 0, 0);
		drain();
		write_reg(RegDocHeight, 32'h0064_0000);
		write_reg(RegPadding, 0);
		write_reg(RegMinGap, 0);
		send(OP_RUN, 0, 0);
		// first span at zero, swapped ends, touching, duplicates, empty span
		send(OP_LOAD, 32'h0010_0000, 0);
		send(OP_LOAD, 32'h0010_0000, 32'h0020_0000);
		send(OP_LOAD, 32'h0030_0000, 32'h0040_0000);
		send(OP_LOAD, 32'h0030_0000, 32'h0040_0000);
		send(OP_LOAD, 32'h0050_0000, 32'h0050_0000);
		send(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
		send(OP_RUN, 0, 0);
		send(OP_LOAD, 32'hFFFF_0000, 32'h8000_0000);
		send(OP_LOAD, 32'h0070_0000, 32'h7FFF_FFFF);
		send(OP_RUN, 0, 0);
		drain();
		// saturating padding, then big min_gap that hides everything
		write_reg(RegPadding, 32'h7FFF_FFFF);
		write_reg(RegDocHeight, 32'hFFFF_FFFF);
		send(OP_LOAD, 32'h0000_1000, 32'h0000_2000);
		send(OP_RUN, 0, 0);
		drain();
		write_reg(RegPadding, 32'h0001_0000);
		write_reg(RegDocHeight, 32'h0064_0000);
		write_reg(RegMinGap, 32'h7FFF_FFFF);
		send(OP_LOAD, 32'h0020_0000, 32'h0021_0000);
		send(OP_RUN, 0, 0);
		drain();
		// shrink height after load: tail edge past doc_height
		write_reg(RegMinGap, 0);
		send(OP_LOAD, 32'h0050_0000, 32'h0060_0000);
		drain();
		write_reg(RegDocHeight, 32'h0030_0000);
		send(OP_RUN, 0, 0);
		drain();

		// random phases with varied settings; sets of loads ended by a run
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: h = 32'h7FFF_FFFF;
				1: h = 1;
				default: h = $urandom_range(16, 32'h0100_0000);
			endcase
			write_reg(RegDocHeight, h);
			write_reg(RegPadding, (ph == 2) ? 0 : $urandom_range(0, h / 16));
			write_reg(RegMinGap, (ph == 3) ? 0 : $urandom_range(0, h / 8));
			for (int r = 0; r < 2; r++) begin
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
				for (int k = 0; k < n; k++) send(OP_LOAD, rnd_coord(h), rnd_coord(h));
				send(OP_RUN, $urandom, $urandom);
			end
			drain();
		end
		drain();

		if (fail_count == 0) $display("interval_union_gap_finder verification clean");
		else $display("interval_union_gap_finder verification failed");
		$finish;
	end
endmodule
